// ===== rtl/ntdt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ntdt_pkg
// Shared types and constants for the network time drift tracker.
// ----------------------------------------------------------------------------
package ntdt_pkg;

	localparam int unsigned WeightDefault = 8;
	localparam int unsigned WeightFull    = 128;
	localparam int unsigned UsPerSecond   = 1000000;
	localparam int unsigned UsPerMs       = 1000;
	localparam int unsigned FracPerUs     = 4294;
	localparam int unsigned QueueDepth    = 2;

	// x / 1000 == (x * MsRecip) >> MsShift and x / 1000000 == (x * SecRecip) >> SecShift
	// for every 32-bit unsigned x
	localparam logic [31:0] MsRecip  = 32'h1062_4DD3;
	localparam int unsigned MsShift  = 38;
	localparam logic [31:0] SecRecip = 32'h431B_DE83;
	localparam int unsigned SecShift = 50;

	typedef enum logic [1:0] {
		OP_RESET = 2'd0,
		OP_SYNC  = 2'd1,
		OP_QNET  = 2'd2,
		OP_QNTP  = 2'd3
	} opcode_t;

	// byte address of the weight register
	localparam logic [1:0] REG_WEIGHT = 2'd0;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] local_us;
		logic [31:0] net_stamp;
		logic [31:0] ntp_base_seconds;
		logic [31:0] ntp_base_fraction;
		logic [15:0] source_address;
		logic [7:0]  hop_depth;
		logic [7:0]  clock_source;
		logic [7:0]  sequence_number;
		logic        sender_synced;
	} in_item_t;

	typedef struct packed {
		logic [31:0] network_time_us;
		logic [22:0] network_time_ms;
		logic [31:0] ntp_secs;
		logic [31:0] ntp_fraction;
		logic [2:0]  status_flags;
		logic [31:0] drift_value;
		logic        sync_accepted;
		logic [7:0]  outgoing_depth;
		logic [7:0]  stored_clock_source;
		logic [7:0]  stored_sequence;
		logic [15:0] stored_source_address;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV_START, ST_DIV_WAIT, ST_SYNC_APPLY, ST_BLEND,
		ST_Q_SUM, ST_Q_MS, ST_Q_SEC, ST_Q_FRAC, ST_Q_MUL, ST_EMIT
	} state_t;

	// divider request/response
	typedef struct packed {
		logic        start;
		logic [31:0] num;
		logic [31:0] den;
		logic        sgn;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quo;
	} div_rsp_t;

endpackage : ntdt_pkg
`default_nettype wire

// ===== rtl/ntdt_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ntdt_if
// Valid/ready channel carrying one packed item.
// ----------------------------------------------------------------------------
interface ntdt_if #(parameter type item_t = logic) ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface : ntdt_if
`default_nettype wire

// ===== rtl/network_time_drift_tracker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// network_time_drift_tracker
// Tracks network time base and drift; answers time queries.
//
//  channel | dir | handshake         | payload
//  in_ch   | in  | valid/ready       | opcode, times, NTP base, source info
//  out_ch  | out | valid/ready       | times, flags, drift, held source info
//  apb     | in  | psel/penable      | drift_filter_weight at 0x0
//
// Reset and unsynced sync items go from idle straight to the emit state, which
// registers the result. Synced sync items and queries each run one serial divide;
// /1000 and /1000000 by reciprocal multiply, /128 by shift.
// arst_n clears flags, base state and queue; weight returns to 8.
// A two-entry input queue and an output register let either side stall.
// ----------------------------------------------------------------------------
module network_time_drift_tracker
	import ntdt_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ntdt_if.sink       in_ch,
	ntdt_if.source     out_ch,
	input  wire logic  psel,
	input  wire logic  penable,
	input  wire logic  pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [7:0] weight_q;
	logic       q_valid, q_ready;
	in_item_t   q_data;
	div_req_t   dreq;
	div_rsp_t   drsp;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_WEIGHT) ? {24'd0, weight_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= 8'(WeightDefault);
		end else if (psel && penable && pwrite && paddr == REG_WEIGHT) begin
			weight_q <= pwdata[7:0];
		end
	end

	ntdt_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.q_valid, .q_ready, .q_data
	);

	ntdt_div u_div (.clk, .arst_n, .req(dreq), .rsp(drsp));

	ntdt_back u_back (
		.clk, .arst_n, .weight(weight_q),
		.q_valid, .q_ready, .q_data,
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
		.dreq, .drsp
	);
endmodule : network_time_drift_tracker
`default_nettype wire

// ===== rtl/ntdt_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ntdt_front
// Input side: accepts items into a short FIFO feeding the engine.
// ----------------------------------------------------------------------------
module ntdt_front
	import ntdt_pkg::*;
#(
	parameter int unsigned DEPTH = QueueDepth
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_data,
	output logic          q_valid,
	input  wire logic     q_ready,
	output in_item_t      q_data
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	in_item_t          mem_q [DEPTH];
	logic [AW-1:0]     wp_q, rp_q;
	logic [AW:0]       cnt_q;
	logic              push, pop;

	assign in_ready = (cnt_q != (AW+1)'(DEPTH));
	assign q_valid  = (cnt_q != '0);
	assign q_data   = mem_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH)) else $error("queue overflow");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0) else $error("pop from empty queue");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");
`endif
endmodule : ntdt_front
`default_nettype wire

// ===== rtl/ntdt_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ntdt_div
// Radix-2 restoring divider, signed or unsigned, one bit per cycle.
// ----------------------------------------------------------------------------
module ntdt_div
	import ntdt_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);
	logic [31:0] rem_q, quo_q, den_q;
	logic [5:0]  cnt_q;
	logic        busy_q, negq_q, zero_q, done_q;
	logic [32:0] trial;
	logic [31:0] na, nd;

	assign na    = (req.sgn && req.num[31]) ? -req.num : req.num;
	assign nd    = (req.sgn && req.den[31]) ? -req.den : req.den;
	assign trial = {rem_q, quo_q[31]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			quo_q  <= na;
			den_q  <= nd;
			negq_q <= req.sgn && (req.num[31] ^ req.den[31]);
			zero_q <= (req.den == '0);
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	always_comb begin
		rsp.done = done_q;
		rsp.quo  = zero_q ? '0 : (negq_q ? -quo_q : quo_q);
	end

`ifndef SYNTH
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("done not a pulse");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q == 6'd1 && !req.start) |=> done_q) else $error("missed done");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0) else $error("busy with zero count");
`endif
endmodule : ntdt_div
`default_nettype wire

// ===== rtl/ntdt_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ntdt_back
// Engine: holds sync state, runs the sync and query sequences on the divider.
// ----------------------------------------------------------------------------
module ntdt_back
	import ntdt_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic [7:0] weight,
	input  wire logic     q_valid,
	output logic          q_ready,
	input  wire in_item_t q_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_item_t     out_data,
	output div_req_t      dreq,
	input  wire div_rsp_t drsp
);
	state_t state_q, state_d;
	in_item_t it_q;
	logic [2:0]  flags_q;
	logic [31:0] bl_q, bn_q, bs_q, bf_q, drift_q;
	logic [15:0] addr_q;
	logic [7:0]  depth_q, csrc_q, seq_q;
	logic [31:0] cur_q, tus_q, e_q, sec_q, frac_q, tmp_q;
	logic [39:0] m1_q, m2_q;
	logic [63:0] prod_q;
	logic        phase_q;
	logic        ovalid_q;
	out_item_t   obuf_q;

	logic [31:0] elapsed;
	logic [7:0]  w;
	logic [31:0] nfrac;
	logic [39:0] blend1, blend2;
	logic        emit;

	assign elapsed = it_q.local_us - bl_q;
	assign w       = (weight > 8'(WeightFull)) ? 8'(WeightFull) : weight;
	assign nfrac   = frac_q + bf_q;
	// add 127 to negative products so the shift by 7 rounds toward zero
	assign blend1  = m1_q + {33'd0, {7{m1_q[39]}}};
	assign blend2  = m2_q + {33'd0, {7{m2_q[39]}}};
	assign emit    = (state_q == ST_EMIT) && (!ovalid_q || out_ready);
	assign out_valid = ovalid_q;
	assign out_data  = obuf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_ready = 1'b0;
		dreq    = '0;
		case (state_q)
			ST_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) begin
					case (opcode_t'(q_data.opcode))
						OP_RESET: state_d = ST_EMIT;
						OP_SYNC:  state_d = q_data.sender_synced ? ST_DIV_START : ST_EMIT;
						default:  state_d = ST_DIV_START;
					endcase
				end
			end
			ST_DIV_START: begin
				dreq.start = 1'b1;
				dreq.sgn   = 1'b1;
				if (it_q.opcode == OP_SYNC) begin
					dreq.num = it_q.net_stamp - bn_q;
					dreq.den = it_q.net_stamp - (elapsed + bn_q);
				end else begin
					dreq.num = elapsed;
					dreq.den = drift_q;
				end
				state_d = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (drsp.done) begin
					state_d = (it_q.opcode == OP_SYNC) ? ST_SYNC_APPLY : ST_Q_SUM;
				end
			end
			ST_SYNC_APPLY: begin
				state_d = (flags_q[1] && cur_q != '0) ? ST_BLEND : ST_EMIT;
			end
			ST_BLEND: begin
				state_d = ST_EMIT;
			end
			ST_Q_SUM: begin
				state_d = ST_Q_MS;
			end
			ST_Q_MS: begin
				state_d = ST_Q_SEC;
			end
			ST_Q_SEC: begin
				state_d = ST_Q_FRAC;
			end
			ST_Q_FRAC: begin
				state_d = ST_Q_MUL;
			end
			ST_Q_MUL: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!ovalid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// 40-bit products: the blend terms fit in 40 bits (8-bit weight by 32-bit value)
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					it_q    <= q_data;
					phase_q <= 1'b0;
				end
			end
			ST_DIV_WAIT: begin
				if (drsp.done) begin
					if (it_q.opcode == OP_SYNC) begin
						cur_q <= drsp.quo;
					end else begin
						tus_q <= bn_q + elapsed + drsp.quo;
						e_q   <= elapsed + drsp.quo;
					end
				end
			end
			ST_SYNC_APPLY: begin
				m1_q <= 40'($signed({{8{cur_q[31]}}, cur_q}) * $signed({1'b0, w}));
				m2_q <= 40'($signed({{8{drift_q[31]}}, drift_q})
					* $signed({1'b0, 8'(WeightFull) - w}));
			end
			ST_BLEND: begin
				cur_q   <= blend1[38:7] + blend2[38:7];
				phase_q <= 1'b1;
			end
			ST_Q_SUM: begin
				prod_q <= 64'(tus_q) * 64'(MsRecip);
			end
			ST_Q_MS: begin
				tmp_q  <= 32'(prod_q[63:MsShift]);
				prod_q <= 64'(e_q) * 64'(SecRecip);
			end
			ST_Q_SEC: begin
				sec_q <= 32'(prod_q[63:SecShift]);
			end
			ST_Q_FRAC: begin
				frac_q <= e_q - 32'(sec_q * 32'(UsPerSecond));
			end
			ST_Q_MUL: begin
				frac_q <= 32'(frac_q * 32'(FracPerUs));
			end
			default: ;
		endcase
	end

	// sync state and output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q  <= '0;
			bl_q     <= '0;
			bn_q     <= '0;
			bs_q     <= '0;
			bf_q     <= '0;
			drift_q  <= '0;
			addr_q   <= '0;
			depth_q  <= '0;
			csrc_q   <= '0;
			seq_q    <= '0;
			ovalid_q <= 1'b0;
			obuf_q   <= '0;
		end else begin
			if (emit) begin
				logic [2:0]  f;
				logic [31:0] dn;
				logic        acc;
				logic [31:0] t_us, t_sec, t_frac;
				logic [22:0] t_ms;
				f      = flags_q;
				dn     = drift_q;
				acc    = 1'b0;
				t_us   = '0;
				t_ms   = '0;
				t_sec  = '0;
				t_frac = '0;
				if (it_q.opcode == OP_RESET) begin
					f = '0;
					addr_q  <= '0;
					depth_q <= '0;
					csrc_q  <= '0;
					seq_q   <= '0;
				end else if (it_q.opcode == OP_SYNC) begin
					if (it_q.sender_synced) begin
						acc = 1'b1;
						if (flags_q[1]) begin
							dn = (cur_q != '0 || phase_q) ? cur_q : drift_q;
						end else if (flags_q[0]) begin
							dn = cur_q;
							f  = {f[2], 2'b10};
						end else begin
							dn = '0;
							f  = f | 3'b001;
						end
						if (it_q.ntp_base_seconds != '0) begin
							f = f | 3'b100;
						end
						addr_q  <= it_q.source_address;
						depth_q <= it_q.hop_depth;
						csrc_q  <= it_q.clock_source;
						seq_q   <= it_q.sequence_number;
						bl_q    <= it_q.local_us;
						bn_q    <= it_q.net_stamp;
						bs_q    <= it_q.ntp_base_seconds;
						bf_q    <= it_q.ntp_base_fraction;
					end
				end else begin
					t_us   = tus_q;
					t_ms   = tmp_q[22:0];
					t_sec  = sec_q + bs_q + 32'(nfrac < bf_q);
					t_frac = nfrac;
				end
				flags_q  <= f;
				drift_q  <= dn;
				ovalid_q <= 1'b1;
				obuf_q.network_time_us <= t_us;
				obuf_q.network_time_ms <= t_ms;
				obuf_q.ntp_secs        <= t_sec;
				obuf_q.ntp_fraction    <= t_frac;
				obuf_q.status_flags    <= f;
				obuf_q.drift_value     <= dn;
				obuf_q.sync_accepted   <= acc;
				if (it_q.opcode == OP_RESET) begin
					obuf_q.outgoing_depth        <= 8'd1;
					obuf_q.stored_clock_source   <= '0;
					obuf_q.stored_sequence       <= '0;
					obuf_q.stored_source_address <= '0;
				end else if (acc) begin
					obuf_q.outgoing_depth        <= it_q.hop_depth + 8'd1;
					obuf_q.stored_clock_source   <= it_q.clock_source;
					obuf_q.stored_sequence       <= it_q.sequence_number;
					obuf_q.stored_source_address <= it_q.source_address;
				end else begin
					obuf_q.outgoing_depth        <= depth_q + 8'd1;
					obuf_q.stored_clock_source   <= csrc_q;
					obuf_q.stored_sequence       <= seq_q;
					obuf_q.stored_source_address <= addr_q;
				end
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && (!ovalid_q || out_ready)) |=> ovalid_q)
		else $error("result not posted");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_ready |-> state_q == ST_IDLE) else $error("take outside idle");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(flags_q[0] && flags_q[1])) else $error("both sync flags set");
`endif
endmodule : ntdt_back
`default_nettype wire

// ===== dv/network_time_drift_tracker_test.sv =====
// ----------------------------------------------------------------------------
// network_time_drift_tracker_test
// Drives sync, query and reset items with random gaps and output stalls,
// predicts every result from an independent model of the drift tracker and
// compares field by field; weight register swept through several settings.
// ----------------------------------------------------------------------------
module network_time_drift_tracker_test
	import ntdt_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MaxCycles = 2000000;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	ntdt_if #(.item_t(in_item_t)) in_ch ();
	ntdt_if #(.item_t(out_item_t)) out_ch ();

	network_time_drift_tracker uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	class time_scoreboard;
		logic [7:0]  weight;
		logic [2:0]  flags;
		logic [31:0] base_local, base_net, base_sec, base_frac, drift;
		logic [15:0] src_addr;
		logic [7:0]  depth, clk_src, seq;
		out_item_t   pending[$];
		int          mismatches;
		int          checked;

		function void clear();
			weight = 8'(WeightDefault);
			flags = 0; base_local = 0; base_net = 0; base_sec = 0; base_frac = 0;
			drift = 0; src_addr = 0; depth = 0; clk_src = 0; seq = 0;
			pending.delete();
			mismatches = 0;
			checked = 0;
		endfunction

		function logic [31:0] sdiv(logic [31:0] num, logic [31:0] den);
			longint n, d;
			n = longint'($signed(num));
			d = longint'($signed(den));
			if (d == 0) return 0;
			return 32'(n / d);
		endfunction

		function void note_input(in_item_t it);
			out_item_t r;
			logic [31:0] el, cur, nxt, us, e, secs, frac;
			longint w;
			r = '0;
			case (opcode_t'(it.opcode))
				OP_RESET: begin
					flags = 0; src_addr = 0; clk_src = 0; depth = 0; seq = 0;
				end
				OP_SYNC: if (it.sender_synced) begin
					el = it.local_us - base_local;
					cur = sdiv(it.net_stamp - base_net,
						it.net_stamp - (el + base_net));
					nxt = 0;
					if (flags[1]) begin
						if (cur != 0) begin
							w = (weight > 128) ? 128 : longint'(weight);
							nxt = 32'((w * longint'($signed(cur))) / 128 +
								((128 - w) * longint'($signed(drift))) / 128);
						end else nxt = drift;
					end else if (flags[0]) begin
						nxt = cur;
						flags = (flags | 3'd2) & ~3'd1;
					end else flags = flags | 3'd1;
					src_addr = it.source_address;
					drift = nxt;
					base_local = it.local_us;
					depth = it.hop_depth;
					clk_src = it.clock_source;
					seq = it.sequence_number;
					base_net = it.net_stamp;
					base_sec = it.ntp_base_seconds;
					base_frac = it.ntp_base_fraction;
					if (base_sec != 0) flags = flags | 3'd4;
					r.sync_accepted = 1;
				end
				default: begin
					el = it.local_us - base_local;
					us = base_net + el + sdiv(el, drift);
					e = us - base_net;
					secs = e / UsPerSecond;
					frac = (e % UsPerSecond) * FracPerUs;
					r.network_time_us = us;
					r.network_time_ms = 23'(us / UsPerMs);
					r.ntp_fraction = frac + base_frac;
					if (r.ntp_fraction < base_frac) secs = secs + 1;
					r.ntp_secs = secs + base_sec;
				end
			endcase
			r.status_flags = flags;
			r.drift_value = drift;
			r.outgoing_depth = depth + 8'd1;
			r.stored_clock_source = clk_src;
			r.stored_sequence = seq;
			r.stored_source_address = src_addr;
			pending.push_back(r);
		endfunction

		function void check_result(out_item_t got);
			out_item_t exp;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
				return;
			end
			exp = pending.pop_front();
			checked++;
			if (got !== exp) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch on result %0d:", checked);
					$display("  us  exp %h got %h", exp.network_time_us, got.network_time_us);
					$display("  ms  exp %h got %h", exp.network_time_ms, got.network_time_ms);
					$display("  sec exp %h got %h  frac exp %h got %h", exp.ntp_secs,
						got.ntp_secs, exp.ntp_fraction, got.ntp_fraction);
					$display("  flags exp %h got %h  drift exp %h got %h", exp.status_flags,
						got.status_flags, exp.drift_value, got.drift_value);
					$display("  acc exp %b got %b  depth exp %h got %h", exp.sync_accepted,
						got.sync_accepted, exp.outgoing_depth, got.outgoing_depth);
					$display("  src/seq/addr exp %h %h %h got %h %h %h",
						exp.stored_clock_source, exp.stored_sequence,
						exp.stored_source_address, got.stored_clock_source,
						got.stored_sequence, got.stored_source_address);
				end
			end
		endfunction
	endclass

	time_scoreboard board;
	int cycles;
	int sent;
	int syncs_sent, queries_sent;
	logic [31:0] now_us, net_us;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		board = new();
		board.clear();
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_ch.valid = 0;
		in_ch.data = '0;
		out_ch.ready = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
	end

	// output side: random stall per item, stretches of no stall
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				out_ch.ready <= 0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
			board.check_result(out_ch.data);
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > MaxCycles) begin
				$display("timeout after %0d cycles", cycles);
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic write_weight(logic [7:0] w);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= REG_WEIGHT;
		pwdata <= {24'd0, w};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		board.weight = w;
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// valid stays up after an accept; drain() or a next call with a gap drops it
	task automatic send_item(in_item_t it);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_ch.data <= it;
		in_ch.valid <= 1;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		board.note_input(it);
		sent++;
		if (opcode_t'(it.opcode) == OP_SYNC) syncs_sent++;
		else if (it.opcode[1]) queries_sent++;
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic in_item_t rand_item(opcode_t op);
		in_item_t it;
		it.opcode = op;
		it.local_us = $urandom();
		it.net_stamp = $urandom();
		it.ntp_base_seconds = ($urandom_range(0, 3) == 0) ? 0 : $urandom();
		it.ntp_base_fraction = $urandom();
		it.source_address = 16'($urandom());
		it.hop_depth = 8'($urandom());
		it.clock_source = 8'($urandom());
		it.sequence_number = 8'($urandom());
		it.sender_synced = ($urandom_range(0, 7) != 0);
		return it;
	endfunction

	// plausible item: network tracks local with small random skew; some syncs jump at random
	task automatic send_tracking(opcode_t op);
		in_item_t it;
		logic [31:0] step;
		it = rand_item(op);
		step = (op == OP_SYNC && $urandom_range(0, 9) == 0) ? $urandom() :
			$urandom_range(1, 5000000);
		now_us = now_us + step;
		net_us = net_us + step + 32'($signed($urandom_range(0, 2000)) - 1000);
		it.local_us = now_us;
		it.net_stamp = net_us;
		send_item(it);
	endtask

	initial begin
		in_item_t it;
		logic [7:0] weights[5];
		sent = 0; syncs_sent = 0; queries_sent = 0;
		now_us = $urandom(); net_us = $urandom();
		weights = '{8'd0, 8'd128, 8'd255, 8'd1, 8'd64};
		@(posedge arst_n);
		@(posedge clk);

		// directed: extremes, each opcode, unsynced sender, zero/nonzero NTP
		it = '0; it.opcode = OP_QNET; send_item(it);
		it.opcode = OP_QNTP; it.local_us = '1; send_item(it);
		it = '1; it.opcode = OP_SYNC; it.sender_synced = 0; send_item(it);
		it = '1; it.opcode = OP_SYNC; send_item(it);
		it = '0; it.opcode = OP_SYNC; it.sender_synced = 1; send_item(it);
		it.local_us = 32'd1000; it.net_stamp = 32'd1010; send_item(it);
		it.local_us = 32'd2000; it.net_stamp = 32'd2000;
		it.ntp_base_seconds = 32'd5; it.ntp_base_fraction = 32'hFFFF_FFF0; send_item(it);
		it.local_us = 32'h8000_0000; it.net_stamp = 32'h7FFF_FFFF; send_item(it);
		it = '1; it.opcode = OP_QNTP; send_item(it);
		it.opcode = OP_QNET; it.local_us = 32'h8000_1000; send_item(it);
		it.opcode = OP_QNTP; it.local_us = 32'h8001_0000; send_item(it);
		it = '1; it.opcode = OP_RESET; send_item(it);
		it.opcode = OP_QNTP; send_item(it);
		for (int k = 0; k < 6; k++) send_tracking(OP_SYNC);
		send_tracking(OP_QNTP);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph > 0) begin
				write_weight(weights[ph - 1]);
				drain();
			end
			for (int k = 0; k < 200; k++) begin
				case ($urandom_range(0, 19))
					0: send_item(rand_item(OP_RESET));
					1, 2: send_item(rand_item(opcode_t'($urandom_range(1, 3))));
					3, 4, 5, 6, 7, 8: send_tracking(OP_SYNC);
					9, 10, 11, 12, 13, 14: send_tracking(OP_QNTP);
					default: send_tracking(OP_QNET);
				endcase
			end
			drain();
		end

		$display("%0d items sent (%0d sync, %0d query), %0d results checked,",
			sent, syncs_sent, queries_sent, board.checked);
		$display("weights 8, 0, 128, 255, 1 and 64; %0d mismatches", board.mismatches);
		if (board.mismatches == 0 && board.pending.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
